// ----- rtl/core/rv32ie_pkg.sv -----
package rv32ie_pkg;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_SUB   = 5'd1,
    OP_AND   = 5'd2,
    OP_OR    = 5'd3,
    OP_XOR   = 5'd4,
    OP_SLL   = 5'd5,
    OP_SRL   = 5'd6,
    OP_SRA   = 5'd7,
    OP_ADDI  = 5'd8,
    OP_ANDI  = 5'd9,
    OP_ORI   = 5'd10,
    OP_XORI  = 5'd11,
    OP_SLTI  = 5'd12,
    OP_SLTIU = 5'd13,
    OP_LW    = 5'd14,
    OP_SW    = 5'd15,
    OP_BEQ   = 5'd16,
    OP_BNE   = 5'd17,
    OP_BLT   = 5'd18,
    OP_BGE   = 5'd19,
    OP_JAL   = 5'd20,
    OP_JALR  = 5'd21
  } op_t;

  localparam int XLEN     = 32;
  localparam int REG_W    = 5;
  localparam int NUM_REGS = 32;
  localparam int IMM_W    = 21;
  localparam int LANES    = 4;

  localparam logic [XLEN-1:0] PC_STEP = 32'd4;

endpackage

// ----- rtl/core/rv32ie_ram.sv -----
module rv32ie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/rv32i_integer_execute_unit_top.sv -----
// From input accept to result valid: register read, then execute with data memory access,
// then writeback at the output register; out_stall holds that result and stalls the input.
// Throughput: one word per cycle while out_stall is low and no memory clear runs; the register
// file and the four byte-lane data memory banks are each read and written at most once per cycle.
// Reset: pc and register valid bits cleared at once; the data memory is cleared by a pass over
// its (MEM_BYTES+3)/4 rows, one row of all four lanes per cycle, with in_stall high.
module rv32i_integer_execute_unit_top
  import rv32ie_pkg::*;
#(
  parameter int MEM_BYTES = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [4:0]             req_type,
  input  logic [REG_W-1:0]       dest_index,
  input  logic [REG_W-1:0]       src1_index,
  input  logic [REG_W-1:0]       src2_index,
  input  logic signed [IMM_W-1:0] immediate,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   status,
  output logic [XLEN-1:0]        next_pc,
  output logic                   reg_written,
  output logic [REG_W-1:0]       written_index,
  output logic [XLEN-1:0]        written_value
);

  localparam int ROWS  = (MEM_BYTES + 3) / 4;
  localparam int ROW_W = $clog2(ROWS);

  // handshake
  logic in_acc, out_acc, s2_free, s1_adv;

  // clearing pass
  logic             clr_active;
  logic [ROW_W-1:0] clr_row;

  // stage 1: operands from register file
  logic            s1_valid;
  op_t             s1_op;
  logic [REG_W-1:0] s1_rd, s1_src1, s1_src2;
  logic [IMM_W-1:0] s1_imm;

  // stage 2: result register
  logic             s2_valid;
  logic             s2_status;
  logic [XLEN-1:0]  s2_npc;
  logic             s2_wr;
  logic [REG_W-1:0] s2_rd;
  logic [XLEN-1:0]  s2_alu_val;
  logic             s2_is_load;
  logic [1:0]       s2_lane;
  logic [XLEN-1:0]  s2_val;

  logic [XLEN-1:0] pc;
  logic [NUM_REGS-1:0] rf_valid;
  logic [XLEN-1:0] rfa_dout, rfb_dout;

  // last register write, covers a read issued on the same edge
  logic             lwb_valid;
  logic [REG_W-1:0] lwb_idx;
  logic [XLEN-1:0]  lwb_val;

  logic [XLEN-1:0] a, b, imm32, addr, ex_val, ex_npc;
  logic            ex_wr, ex_status, ex_load, ex_store, in_bounds;
  logic [1:0]      lane;

  logic [7:0]       bank_dout  [LANES];
  logic [7:0]       bank_wdata [LANES];
  logic [ROW_W-1:0] bank_waddr [LANES];
  logic [ROW_W-1:0] bank_raddr [LANES];
  logic [XLEN-1:0]  load_word;

  assign out_valid = s2_valid;
  assign out_acc   = s2_valid && !out_stall;
  assign s2_free   = !s2_valid || !out_stall;
  assign s1_adv    = s1_valid && s2_free;
  assign in_stall  = clr_active || (s1_valid && !s2_free);
  assign in_acc    = in_valid && !in_stall;

  // register file: two copies, one per read port, written together
  rv32ie_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_a (
    .clk   (clk),
    .we    (out_acc && s2_wr),
    .waddr (s2_rd),
    .wdata (s2_val),
    .re    (in_acc),
    .raddr (src1_index),
    .rdata (rfa_dout)
  );

  rv32ie_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_b (
    .clk   (clk),
    .we    (out_acc && s2_wr),
    .waddr (s2_rd),
    .wdata (s2_val),
    .re    (in_acc),
    .raddr (src2_index),
    .rdata (rfb_dout)
  );

  // operand forwarding: unwritten result in stage 2, then last write, then memory
  always_comb begin
    if (s2_valid && s2_wr && s2_rd == s1_src1) begin
      a = s2_val;
    end else if (lwb_valid && lwb_idx == s1_src1) begin
      a = lwb_val;
    end else begin
      a = rf_valid[s1_src1] ? rfa_dout : '0;
    end
    if (s2_valid && s2_wr && s2_rd == s1_src2) begin
      b = s2_val;
    end else if (lwb_valid && lwb_idx == s1_src2) begin
      b = lwb_val;
    end else begin
      b = rf_valid[s1_src2] ? rfb_dout : '0;
    end
  end

  assign imm32     = {{(XLEN-IMM_W){s1_imm[IMM_W-1]}}, s1_imm};
  assign addr      = a + imm32;
  assign lane      = addr[1:0];
  assign in_bounds = ({1'b0, addr} + 33'd3) < 33'(MEM_BYTES);

  always_comb begin
    ex_val    = '0;
    ex_wr     = 1'b0;
    ex_status = 1'b0;
    ex_load   = 1'b0;
    ex_store  = 1'b0;
    ex_npc    = pc + PC_STEP;
    case (s1_op)
      OP_ADD:   begin ex_val = a + b; ex_wr = 1'b1; end
      OP_SUB:   begin ex_val = a - b; ex_wr = 1'b1; end
      OP_AND:   begin ex_val = a & b; ex_wr = 1'b1; end
      OP_OR:    begin ex_val = a | b; ex_wr = 1'b1; end
      OP_XOR:   begin ex_val = a ^ b; ex_wr = 1'b1; end
      OP_SLL:   begin ex_val = a << b[4:0]; ex_wr = 1'b1; end
      OP_SRL:   begin ex_val = a >> b[4:0]; ex_wr = 1'b1; end
      OP_SRA:   begin ex_val = $unsigned($signed(a) >>> b[4:0]); ex_wr = 1'b1; end
      OP_ADDI:  begin ex_val = addr; ex_wr = 1'b1; end
      OP_ANDI:  begin ex_val = a & imm32; ex_wr = 1'b1; end
      OP_ORI:   begin ex_val = a | imm32; ex_wr = 1'b1; end
      OP_XORI:  begin ex_val = a ^ imm32; ex_wr = 1'b1; end
      OP_SLTI:  begin
        ex_val = {31'd0, $signed(a) < $signed(imm32)};
        ex_wr  = 1'b1;
      end
      OP_SLTIU: begin ex_val = {31'd0, a < imm32}; ex_wr = 1'b1; end
      OP_LW: begin
        if (in_bounds) begin
          ex_load = 1'b1;
          ex_wr   = 1'b1;
        end else begin
          ex_status = 1'b1;
        end
      end
      OP_SW: begin
        if (in_bounds) begin
          ex_store = 1'b1;
        end else begin
          ex_status = 1'b1;
        end
      end
      OP_BEQ: if (a == b) ex_npc = pc + imm32;
      OP_BNE: if (a != b) ex_npc = pc + imm32;
      OP_BLT: if ($signed(a) < $signed(b)) ex_npc = pc + imm32;
      OP_BGE: if (!($signed(a) < $signed(b))) ex_npc = pc + imm32;
      OP_JAL: begin
        ex_val = pc + PC_STEP;
        ex_wr  = 1'b1;
        ex_npc = pc + imm32;
      end
      OP_JALR: begin
        ex_val = pc + PC_STEP;
        ex_wr  = 1'b1;
        ex_npc = addr & ~32'd1;
      end
      default: ;
    endcase
    if (s1_rd == '0) begin
      ex_wr = 1'b0;
    end
  end

  // data memory: four byte lanes, a word at any alignment touches each lane once
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic [29:0] row;
    logic [1:0]  k;
    assign row = addr[31:2] + {29'd0, (2'(j) < lane)};
    assign k   = 2'(j) - lane;
    assign bank_raddr[j] = row[ROW_W-1:0];
    assign bank_waddr[j] = clr_active ? clr_row : row[ROW_W-1:0];
    assign bank_wdata[j] = clr_active ? 8'd0 : b[8*k +: 8];

    rv32ie_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
      .clk   (clk),
      .we    (clr_active || (s1_adv && ex_store)),
      .waddr (bank_waddr[j]),
      .wdata (bank_wdata[j]),
      .re    (s1_adv && ex_load),
      .raddr (bank_raddr[j]),
      .rdata (bank_dout[j])
    );
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      load_word[8*k +: 8] = bank_dout[2'(k) + s2_lane];
    end
  end

  assign s2_val = s2_is_load ? load_word : s2_alu_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_row    <= '0;
    end else if (clr_active) begin
      if (clr_row == ROW_W'(ROWS - 1)) begin
        clr_active <= 1'b0;
      end
      clr_row <= clr_row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (in_acc) begin
      s1_op   <= op_t'(req_type);
      s1_rd   <= dest_index;
      s1_src1 <= src1_index;
      s1_src2 <= src2_index;
      s1_imm  <= immediate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      pc       <= '0;
    end else begin
      if (s1_adv) begin
        s2_valid <= 1'b1;
        pc       <= ex_npc;
      end else if (out_acc) begin
        s2_valid <= 1'b0;
      end
    end
    if (s1_adv) begin
      s2_status  <= ex_status;
      s2_npc     <= ex_npc;
      s2_wr      <= ex_wr;
      s2_rd      <= s1_rd;
      s2_alu_val <= ex_val;
      s2_is_load <= ex_load;
      s2_lane    <= lane;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid  <= '0;
      lwb_valid <= 1'b0;
    end else if (out_acc && s2_wr) begin
      rf_valid[s2_rd] <= 1'b1;
      lwb_valid       <= 1'b1;
    end
    if (out_acc && s2_wr) begin
      lwb_idx <= s2_rd;
      lwb_val <= s2_val;
    end
  end

  assign status        = s2_status;
  assign next_pc       = s2_npc;
  assign reg_written   = s2_wr;
  assign written_index = s2_wr ? s2_rd : '0;
  assign written_value = s2_wr ? s2_val : '0;

endmodule

// ----- rtl/core/rv32ie_checker.sv -----
module rv32ie_checker
  import rv32ie_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             status,
  input logic [XLEN-1:0]  next_pc,
  input logic             reg_written,
  input logic [REG_W-1:0] written_index,
  input logic [XLEN-1:0]  written_value
);

  // memory clear runs right after reset, so input must be held off
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled during memory clear");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_pc) && $stable(written_value))
    else $error("stalled result word changed");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reg_written |-> written_index == '0 && written_value == '0)
    else $error("write fields set without a register write");

  a_write_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && reg_written |-> written_index != '0 && !status)
    else $error("register write to x0 or on a failed access");

endmodule

bind rv32i_integer_execute_unit_top rv32ie_checker u_checker (.*);
